// File: src/tsd_pkg.sv
// tsd_pkg: shared types and constants for the tlv stream deframer
// used by every module of the block and by its checker
package tsd_pkg;

	localparam int unsigned TSD_QUEUE_DEPTH = 4;
	localparam logic [15:0] FIX_FROM = 16'd3;
	localparam logic [15:0] FIX_TO   = 16'd4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_T0,
		PH_T1,
		PH_L0,
		PH_L1,
		PH_VAL
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_OVERRUN = 2'd1,
		ST_ZERO    = 2'd2,
		ST_TRUNC   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_BIG_ENDIAN = 2'd0,
		REG_ZERO_STOPS = 2'd1,
		REG_FIX_ENABLE = 2'd2,
		REG_FIX_TYPE   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic        big_endian;
		logic        zero_stops;
		logic        fix_enable;
		logic [15:0] fix_type;
	} cfg_t;

	// one queue entry: a first result and, when two is set, a trailing status
	typedef struct packed {
		kind_t       kind_a;
		logic [15:0] rtype;
		logic [15:0] rlen;
		logic [7:0]  vbyte;
		logic        vlast;
		status_t     status;
		logic        two;
	} entry_t;

endpackage

// File: src/tsd_front.sv
// tsd_front: byte parser, holds the parse state and classifies each word
// into at most one queue entry; depends on tsd_pkg
module tsd_front import tsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        buffer_start,
	input  logic [15:0] buffer_length,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        push,
	output entry_t      push_entry
);

	phase_t      phase_q, ph, ph_d;
	logic [15:0] bl_q, bl, bl_d, nbl;
	logic [15:0] th_q, th, th_d;
	logic [15:0] lh_q, lh, lh_d;
	logic [15:0] vl_q, vl, vl_d;
	logic [15:0] t_new, l_new, l_fix;
	logic        has;
	logic        accept;
	entry_t      e;

	function automatic entry_t short_hdr(input logic [15:0] t, input logic zrs);
		entry_t r;
		r.rtype  = t;
		r.rlen   = '0;
		r.vbyte  = '0;
		r.vlast  = 1'b0;
		if (zrs && t == 16'd0) begin
			r.kind_a = KIND_STATUS;
			r.status = ST_ZERO;
			r.two    = 1'b0;
		end else begin
			r.kind_a = KIND_HEADER;
			r.status = ST_TRUNC;
			r.two    = 1'b1;
		end
		return r;
	endfunction

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign push     = accept && has;
	assign push_entry = e;

	always_comb begin
		ph = phase_q;
		bl = bl_q;
		th = th_q;
		lh = lh_q;
		vl = vl_q;
		if (buffer_start) begin
			bl = buffer_length;
			th = '0;
			lh = '0;
			vl = '0;
			ph = PH_T0;
		end
		nbl   = bl - 16'd1;
		t_new = cfg.big_endian ? {th[15:8], data_byte} : {data_byte, th[7:0]};
		l_new = cfg.big_endian ? {lh[15:8], data_byte} : {data_byte, lh[7:0]};
		l_fix = (cfg.fix_enable && th == cfg.fix_type && l_new == FIX_FROM) ? FIX_TO : l_new;
		ph_d = ph;
		bl_d = bl;
		th_d = th;
		lh_d = lh;
		vl_d = vl;
		has  = 1'b0;
		e.kind_a = KIND_HEADER;
		e.rtype  = th;
		e.rlen   = lh;
		e.vbyte  = '0;
		e.vlast  = 1'b0;
		e.status = ST_NORMAL;
		e.two    = 1'b0;
		if (buffer_start && buffer_length == 16'd0) begin
			has      = 1'b1;
			e.kind_a = KIND_STATUS;
			ph_d     = PH_IDLE;
		end else if (ph == PH_IDLE || bl == 16'd0) begin
			ph_d = PH_IDLE;
		end else begin
			bl_d = nbl;
			unique case (ph)
				PH_T0: begin
					if (bl == 16'd1) begin
						th_d = '0;
						lh_d = '0;
						has  = 1'b1;
						e    = short_hdr(16'd0, cfg.zero_stops);
						ph_d = PH_IDLE;
					end else begin
						th_d = cfg.big_endian ? {data_byte, 8'd0} : {8'd0, data_byte};
						ph_d = PH_T1;
					end
				end
				PH_T1: begin
					th_d = t_new;
					if (nbl < 16'd2) begin
						lh_d = '0;
						has  = 1'b1;
						e    = short_hdr(t_new, cfg.zero_stops);
						ph_d = PH_IDLE;
					end else begin
						ph_d = PH_L0;
					end
				end
				PH_L0: begin
					lh_d = cfg.big_endian ? {data_byte, 8'd0} : {8'd0, data_byte};
					ph_d = PH_L1;
				end
				PH_L1: begin
					has = 1'b1;
					if (cfg.zero_stops && th == 16'd0 && l_new == 16'd0) begin
						lh_d     = l_new;
						e.rlen   = l_new;
						e.kind_a = KIND_STATUS;
						e.status = ST_ZERO;
						ph_d     = PH_IDLE;
					end else if (l_fix > nbl) begin
						lh_d     = l_fix;
						e.rlen   = l_fix;
						e.kind_a = KIND_STATUS;
						e.status = ST_OVERRUN;
						ph_d     = PH_IDLE;
					end else begin
						lh_d   = l_fix;
						e.rlen = l_fix;
						if (l_fix == 16'd0) begin
							if (nbl == 16'd0) begin
								e.two = 1'b1;
								ph_d  = PH_IDLE;
							end else begin
								ph_d = PH_T0;
							end
						end else begin
							vl_d = l_fix;
							ph_d = PH_VAL;
						end
					end
				end
				PH_VAL: begin
					has      = 1'b1;
					e.kind_a = KIND_VALUE;
					e.vbyte  = data_byte;
					e.vlast  = (vl <= 16'd1);
					vl_d     = (vl != 16'd0) ? vl - 16'd1 : 16'd0;
					if (vl_d == 16'd0) begin
						if (nbl == 16'd0) begin
							e.two = 1'b1;
							ph_d  = PH_IDLE;
						end else begin
							ph_d = PH_T0;
						end
					end
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bl_q    <= '0;
			th_q    <= '0;
			lh_q    <= '0;
			vl_q    <= '0;
		end else if (accept) begin
			phase_q <= ph_d;
			bl_q    <= bl_d;
			th_q    <= th_d;
			lh_q    <= lh_d;
			vl_q    <= vl_d;
		end
	end

endmodule

// File: src/tsd_queue.sv
// tsd_queue: small register fifo of parsed entries between front and back
// depends on tsd_pkg
module tsd_queue import tsd_pkg::*; #(
	parameter int unsigned DEPTH = TSD_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: src/tsd_back.sv
// tsd_back: expands queue entries into result words and holds the output register
// depends on tsd_pkg
module tsd_back import tsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] record_type,
	output logic [15:0] record_length,
	output logic [7:0]  value_byte,
	output logic        value_last,
	output logic [1:0]  end_status,
	output logic        last
);

	logic    valid_q;
	logic    sub_q;
	logic    load;
	logic    take;
	kind_t   kind_q;
	logic [15:0] type_q, len_q;
	logic [7:0]  vbyte_q;
	logic        vlast_q;
	status_t     status_q;
	logic        last_q;

	assign load = !valid_q || !out_stall;
	assign take = load && !q_empty;
	assign pop  = take && (sub_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (take) begin
				sub_q <= head.two && !sub_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_q <= head.rtype;
			len_q  <= head.rlen;
			if (sub_q) begin
				kind_q   <= KIND_STATUS;
				vbyte_q  <= '0;
				vlast_q  <= 1'b0;
				status_q <= head.status;
				last_q   <= 1'b1;
			end else begin
				kind_q   <= head.kind_a;
				vbyte_q  <= head.vbyte;
				vlast_q  <= head.vlast;
				status_q <= (head.kind_a == KIND_STATUS) ? head.status : ST_NORMAL;
				last_q   <= !head.two;
			end
		end
	end

	assign out_valid     = valid_q;
	assign result_kind   = kind_q;
	assign record_type   = type_q;
	assign record_length = len_q;
	assign value_byte    = vbyte_q;
	assign value_last    = vlast_q;
	assign end_status    = status_q;
	assign last          = last_q;

endmodule

// File: src/tlv_stream_deframer.sv
// tlv_stream_deframer: top level, configuration registers, front parser,
// entry queue and result back end; depends on tsd_pkg, tsd_front, tsd_queue, tsd_back
// Takes one buffer word per cycle, unless in_stall is raised because the queue is full, and
// parses it as 16-bit type / 16-bit length records in the byte order set by register 0. The
// front parser writes at most one entry per word to a QUEUE_DEPTH-entry queue; the back end
// turns entries into result words, one per cycle unless out_stall holds the output. A word
// that gives two results (a header or last value byte followed by an end status) takes two
// result words at the output, and the queue absorbs that. The first result of a word passes
// through the queue and then the output register before it is on the output. Register writes
// are always ready and take effect on the next word.
module tlv_stream_deframer import tsd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = TSD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        buffer_start,
	input  logic [15:0] buffer_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] record_type,
	output logic [15:0] record_length,
	output logic [7:0]  value_byte,
	output logic        value_last,
	output logic [1:0]  end_status,
	output logic        last
);

	cfg_t   cfg_q;
	logic   push, pop, q_full, q_empty;
	entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.big_endian <= 1'b0;
			cfg_q.zero_stops <= 1'b1;
			cfg_q.fix_enable <= 1'b0;
			cfg_q.fix_type   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_BIG_ENDIAN: cfg_q.big_endian <= cfg_data[0];
				REG_ZERO_STOPS: cfg_q.zero_stops <= cfg_data[0];
				REG_FIX_ENABLE: cfg_q.fix_enable <= cfg_data[0];
				REG_FIX_TYPE:   cfg_q.fix_type   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.buffer_start (buffer_start),
		.buffer_length(buffer_length),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	tsd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	tsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.record_type  (record_type),
		.record_length(record_length),
		.value_byte   (value_byte),
		.value_last   (value_last),
		.end_status   (end_status),
		.last         (last)
	);

endmodule

// File: src/tsd_checker.sv
// tsd_checker: port-level checks on the result channel of the deframer
// depends on tsd_pkg; bound to tlv_stream_deframer below
module tsd_checker import tsd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  result_kind,
	input logic [15:0] record_type,
	input logic [15:0] record_length,
	input logic [7:0]  value_byte,
	input logic        value_last,
	input logic [1:0]  end_status,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) &&
		$stable(record_type) && $stable(record_length) && $stable(value_byte) &&
		$stable(end_status) && $stable(last))
		else $error("stalled result word changed");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STATUS |-> last)
		else $error("end status is not the last result of its word");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_STATUS |-> end_status == ST_NORMAL)
		else $error("end status set on a non-status result");

	a_value_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_VALUE |-> value_byte == 8'd0 && !value_last)
		else $error("value fields set on a non-value result");

endmodule

bind tlv_stream_deframer tsd_checker u_tsd_checker (.*);
